// File: rtl/core/spts_pkg.sv
// package with types and constants of the step pulse timestamp scheduler
package spts_pkg;

  localparam int unsigned QueueDepth = 256;
  localparam int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned LevelW     = 9;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned WidthW     = 16;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [WidthW-1:0] PulseWidthReset  = WidthW'(50);
  localparam logic [LevelW-1:0] RefillThreshReset = LevelW'(128);

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdPush  = 2'd1,
    CmdStart = 2'd2
  } cmd_e;

  typedef enum logic {
    RegPulseWidth  = 1'b0,
    RegRefillThres = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TimeW-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic              step_level;
    logic              running;
    logic              refill_request;
    logic              push_rejected;
    logic [LevelW-1:0] queue_level;
  } out_item_t;

endpackage

// File: rtl/core/step_pulse_timestamp_scheduler.sv
// top level of the step pulse timestamp scheduler
//
// One item is taken every clock cycle while input ready is high, and each item
// gives one registered result. Tick items advance a 32-bit counter; push items
// append a step time to a ring queue held in a synchronous memory of QueueDepth
// 32-bit words. A pop (on start or at the end of a pulse) reads the head word, and
// the registered read data serves directly as the current target, so a tick right
// after a pop already compares against the new target. The
// queue memory is not cleared after reset and needs no startup pass. Results go
// through a two-entry output buffer, so input transfers continue for one item
// while a result waits on the output side; input ready drops only when both
// entries are full.
module step_pulse_timestamp_scheduler
  import spts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  // configuration registers
  logic [WidthW-1:0] pulse_width_q;
  logic [LevelW-1:0] refill_thr_q;
  logic              cfg_wr;
  reg_e              cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_width_q <= PulseWidthReset;
      refill_thr_q  <= RefillThreshReset;
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegPulseWidth:  pulse_width_q <= pwdata[WidthW-1:0];
        RegRefillThres: refill_thr_q  <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegPulseWidth:  prdata = {{(DataW-WidthW){1'b0}}, pulse_width_q};
      RegRefillThres: prdata = {{(DataW-LevelW){1'b0}}, refill_thr_q};
      default:        prdata = '0;
    endcase
  end

  // scheduler state
  logic [TimeW-1:0] tick_q, tick_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]  wr_idx_q, wr_idx_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pulse_q, pulse_d;
  logic             run_q, run_d;

  // queue memory, registered read data is the current target
  logic [TimeW-1:0] queue_mem [QueueDepth];
  logic [TimeW-1:0] target_q;
  logic             mem_wr, mem_rd;

  logic             accept;
  logic             rejected;
  logic             not_empty, full;
  logic [WidthW-1:0] width_eff;
  logic [TimeW-1:0] pulse_end;
  out_item_t        result;

  assign accept    = in_valid_i & in_ready_o;
  assign not_empty = (count_q != '0);
  assign full      = (count_q == CntW'(QueueDepth));
  assign width_eff = (pulse_width_q == '0) ? WidthW'(1) : pulse_width_q;
  assign pulse_end = target_q + {{(TimeW-WidthW){1'b0}}, width_eff};

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    next_idx = (idx == IdxW'(QueueDepth - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  always_comb begin
    tick_d   = tick_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    count_d  = count_q;
    pulse_d  = pulse_q;
    run_d    = run_q;
    mem_wr   = 1'b0;
    mem_rd   = 1'b0;
    rejected = 1'b0;
    if (accept) begin
      case (in_data_i.cmd)
        CmdTick: begin
          if (pulse_q) begin
            if (tick_q == pulse_end) begin
              pulse_d = 1'b0;
              if (not_empty) begin
                mem_rd   = 1'b1;
                rd_idx_d = next_idx(rd_idx_q);
                count_d  = count_q - CntW'(1);
              end else begin
                run_d = 1'b0;
              end
            end
          end else if (run_q && tick_q == target_q) begin
            pulse_d = 1'b1;
          end
          tick_d = tick_q + TimeW'(1);
        end
        CmdPush: begin
          if (full) begin
            rejected = 1'b1;
          end else begin
            mem_wr   = 1'b1;
            wr_idx_d = next_idx(wr_idx_q);
            count_d  = count_q + CntW'(1);
          end
        end
        CmdStart: begin
          if (!run_q && not_empty) begin
            mem_rd   = 1'b1;
            rd_idx_d = next_idx(rd_idx_q);
            count_d  = count_q - CntW'(1);
            run_d    = 1'b1;
            pulse_d  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      count_q  <= '0;
      pulse_q  <= 1'b0;
      run_q    <= 1'b0;
    end else begin
      tick_q   <= tick_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      count_q  <= count_d;
      pulse_q  <= pulse_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      queue_mem[wr_idx_q] <= in_data_i.timestamp;
    end
    if (mem_rd) begin
      target_q <= queue_mem[rd_idx_q];
    end
  end

  // result of the item just taken
  always_comb begin
    result.step_level     = pulse_d;
    result.running        = run_d;
    result.refill_request = run_d &&
                            ({{(CntW+LevelW){1'b0}}, count_d} <=
                             {{(2*CntW){1'b0}}, refill_thr_q});
    result.push_rejected  = rejected;
    result.queue_level    = LevelW'(count_d);
  end

  // two-entry output buffer
  out_item_t out_q, skid_q;
  logic      out_vld_q, skid_vld_q;

  assign in_ready_o  = ~skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !out_ready_i) begin
      if (accept) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !out_ready_i) begin
      if (accept) begin
        skid_q <= result;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= result;
    end
  end

endmodule

// File: tb/step_sched_tb_pkg.sv
// scoreboard class that predicts and checks the scheduler status items
`timescale 1ns / 1ps
package step_sched_tb_pkg;
  import spts_pkg::*;

  class pulse_tracker;
    logic [WidthW-1:0] width_reg;
    logic [LevelW-1:0] thresh_reg;
    logic [TimeW-1:0]  ticks;
    logic [TimeW-1:0]  stamps [QueueDepth];
    logic [IdxW-1:0]   rd_idx;
    logic [IdxW-1:0]   wr_idx;
    logic [CntW-1:0]   level;
    logic [TimeW-1:0]  target;
    bit                pulsing;
    bit                running;
    out_item_t         due_status [$];
    int unsigned       errors;

    function new();
      width_reg  = PulseWidthReset;
      thresh_reg = RefillThreshReset;
      ticks      = '0;
      rd_idx     = '0;
      wr_idx     = '0;
      level      = '0;
      target     = '0;
      pulsing    = 1'b0;
      running    = 1'b0;
      errors     = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("check failed: %s", msg);
    endfunction

    function void set_reg(reg_e r, logic [DataW-1:0] word);
      case (r)
        RegPulseWidth:  width_reg  = word[WidthW-1:0];
        RegRefillThres: thresh_reg = word[LevelW-1:0];
        default: ;
      endcase
    endfunction

    function bit pop_next();
      if (level == 0) return 1'b0;
      target = stamps[rd_idx];
      rd_idx++;
      level--;
      return 1'b1;
    endfunction

    // one transfer in, one status item out
    function void apply_item(in_item_t it);
      logic [TimeW-1:0] w;
      out_item_t st;
      bit rejected;
      rejected = 1'b0;
      case (it.cmd)
        CmdTick: begin
          w = (width_reg == '0) ? TimeW'(1) : TimeW'(width_reg);
          if (pulsing) begin
            if (ticks == target + w) begin
              pulsing = 1'b0;
              if (!pop_next()) running = 1'b0;
            end
          end else if (running && ticks == target) begin
            pulsing = 1'b1;
          end
          ticks = ticks + 1;
        end
        CmdPush: begin
          if (level >= QueueDepth) begin
            rejected = 1'b1;
          end else begin
            stamps[wr_idx] = it.timestamp;
            wr_idx++;
            level++;
          end
        end
        CmdStart: begin
          if (!running && pop_next()) begin
            running = 1'b1;
            pulsing = 1'b0;
          end
        end
        default: ;
      endcase
      st.step_level     = pulsing;
      st.running        = running;
      st.refill_request = running && (level <= thresh_reg);
      st.push_rejected  = rejected;
      st.queue_level    = LevelW'(level);
      due_status.push_back(st);
    endfunction

    function void compare_status(out_item_t got);
      out_item_t want;
      if (due_status.size() == 0) begin
        flag($sformatf("status %h arrived with nothing outstanding", got));
        return;
      end
      want = due_status.pop_front();
      if (got.step_level !== want.step_level || got.running !== want.running ||
          got.refill_request !== want.refill_request ||
          got.push_rejected !== want.push_rejected ||
          got.queue_level !== want.queue_level) begin
        flag($sformatf({"status exp/got: step %0b/%0b run %0b/%0b refill %0b/%0b ",
                        "rejected %0b/%0b level %0d/%0d"},
                       want.step_level, got.step_level, want.running, got.running,
                       want.refill_request, got.refill_request,
                       want.push_rejected, got.push_rejected,
                       want.queue_level, got.queue_level));
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// top-level testbench of the step pulse timestamp scheduler
`timescale 1ns / 1ps
module tb_top;
  import spts_pkg::*;
  import step_sched_tb_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int unsigned CycleLimit = 1000000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  pulse_tracker trk;
  int unsigned  items_sent = 0;
  int unsigned  cycles     = 0;
  bit           calm       = 1'b0;

  step_pulse_timestamp_scheduler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) trk.compare_status(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [TimeW-1:0] eff_width();
    return (trk.width_reg == '0) ? TimeW'(1) : TimeW'(trk.width_reg);
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [TimeW-1:0] stamp);
    in_item_t it;
    it.cmd       = cmd;
    it.timestamp = stamp;
    if (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 34);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    trk.apply_item(it);
    items_sent++;
  endtask

  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (trk.due_status.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e r, input logic [DataW-1:0] value);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] word;
    mask = (r == RegPulseWidth) ? DataW'(16'hffff) : DataW'(9'h1ff);
    word = (value & mask) | ($urandom & ~mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(r));
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    trk.set_reg(r, word);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (word & mask))
      trk.flag($sformatf("register %s read back %h, written %h", r.name(), prdata, word));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [DataW-1:0] width, input logic [DataW-1:0] thresh);
    drain(4);
    write_reg(RegPulseWidth, width);
    write_reg(RegRefillThres, thresh);
  endtask

  // pushes a reachable chain of step times, starts and ticks until the block stops
  task automatic run_sequence(input int unsigned n_steps, input int unsigned max_extra);
    logic [TimeW-1:0] w;
    logic [TimeW-1:0] head;
    logic [TimeW-1:0] next_at;
    int unsigned      extra;
    int unsigned      pre;
    int unsigned      r;
    w = eff_width();
    if ($urandom_range(0, 3) == 0) send(CmdStart, $urandom);
    head    = trk.ticks + $urandom_range(0, 6);
    next_at = head;
    for (int i = 0; i < n_steps; i++) begin
      send(CmdPush, next_at);
      next_at = next_at + w + 1 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
    end
    pre = $urandom_range(0, head - trk.ticks);
    repeat (pre) send(CmdTick, $urandom);
    send(CmdStart, $urandom);
    extra = 0;
    while (trk.running) begin
      if ($urandom_range(0, 39) == 0) drain(0);
      r = $urandom_range(0, 99);
      if (r < 6 && extra < max_extra) begin
        send(CmdPush, next_at);
        next_at = next_at + w + 1 + $urandom_range(0, 4);
        extra++;
      end else if (r < 10) begin
        send(CmdStart, $urandom);
      end else if (r < 14) begin
        send(CmdUnused, $urandom);
      end else begin
        send(CmdTick, $urandom);
      end
    end
  endtask

  initial begin
    int unsigned      phase;
    logic [TimeW-1:0] base;
    trk = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unused code, start on empty queue, due-now and back-to-back targets
    send(CmdUnused, '1);
    send(CmdStart, '0);
    send(CmdTick, '1);
    send(CmdPush, trk.ticks);
    send(CmdPush, trk.ticks + eff_width() + 1);
    send(CmdStart, '0);
    send(CmdStart, '1);
    send(CmdUnused, '0);
    while (trk.running) send(CmdTick, $urandom);

    phase = 0;
    while (items_sent < 300) begin
      case (phase)
        0: configure(0, 0);
        1: configure(1, 511);
        default: configure($urandom_range(1, 6),
                           ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(0, 6));
      endcase
      calm = (phase == 1 || phase == 2);
      repeat ($urandom_range(1, 3)) run_sequence($urandom_range(1, 8), 3);
      phase++;
    end
    calm = 1'b0;

    configure(16'hffff, 1);

    // fill the queue to the brim, overflow it, then serve a few steps
    configure(1, 250);
    base = trk.ticks + 3;
    for (int i = 0; i < QueueDepth; i++) begin
      if (i < 24) send(CmdPush, base + 2 * i);
      else if (i == QueueDepth - 1) send(CmdPush, '1);
      else send(CmdPush, $urandom);
    end
    send(CmdPush, '1);
    send(CmdStart, '0);
    send(CmdPush, '0);
    send(CmdPush, $urandom);
    repeat (36) send(CmdTick, $urandom);

    drain(8);
    if (trk.errors == 0 && trk.due_status.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
